>>> rtl/tcwc_pkg.sv
// ----------------------------------------------------------------------------
// tcwc_pkg
// Shared widths, reset values, register codes and types for the
// three-color weighted composite core.
// ----------------------------------------------------------------------------
`default_nettype none

package tcwc_pkg;

  localparam int SampleW  = 32;
  localparam int ScaleW   = 32;
  localparam int ColorW   = 24;
  localparam int CompW    = 8;
  localparam int NumComp  = 3;
  localparam int FracW    = 16;
  localparam int WeightW  = FracW + 1;
  localparam int ProdW    = WeightW + CompW;
  localparam int SumW     = ProdW + 1;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 64;

  localparam logic [WeightW-1:0]  WeightOne   = WeightW'(1) << FracW;
  localparam logic [CfgDataW-1:0] PrepReset   = 64'h0001_0000_0000_0000;
  localparam logic [ColorW-1:0]   ColorAReset = 24'hFF0000;
  localparam logic [ColorW-1:0]   ColorBReset = 24'h00FF00;
  localparam logic [ColorW-1:0]   ColorCReset = 24'h0000FF;
  localparam logic [CompW-1:0]    CompMax     = 8'hFF;

  typedef enum logic [CfgIdxW-1:0] {
    REG_PREP_A  = 3'd0,
    REG_PREP_B  = 3'd1,
    REG_PREP_C  = 3'd2,
    REG_COLOR_A = 3'd3,
    REG_COLOR_B = 3'd4,
    REG_COLOR_C = 3'd5
  } cfg_reg_e;

  // stage enables shared by the lanes and the merge stage
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } stage_en_t;

  // index 2 red, 1 green, 0 blue
  typedef logic [NumComp-1:0][ProdW-1:0] comp_prod_t;

endpackage

`default_nettype wire

>>> rtl/tcwc_if.sv
// ----------------------------------------------------------------------------
// tcwc interfaces
// Valid/ready channels for pixel input, color output and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface tcwc_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [tcwc_pkg::SampleW-1:0]  sample_a;
  logic signed [tcwc_pkg::SampleW-1:0]  sample_b;
  logic signed [tcwc_pkg::SampleW-1:0]  sample_c;
  logic                                 nodata_a;
  logic                                 nodata_b;
  logic                                 nodata_c;

  modport source (output valid, sample_a, sample_b, sample_c,
                  nodata_a, nodata_b, nodata_c, input ready);
  modport sink   (input valid, sample_a, sample_b, sample_c,
                  nodata_a, nodata_b, nodata_c, output ready);
endinterface

interface tcwc_out_if;
  logic                        valid;
  logic                        ready;
  logic [tcwc_pkg::CompW-1:0]  red;
  logic [tcwc_pkg::CompW-1:0]  green;
  logic [tcwc_pkg::CompW-1:0]  blue;
  logic                        no_value;

  modport source (output valid, red, green, blue, no_value, input ready);
  modport sink   (input valid, red, green, blue, no_value, output ready);
endinterface

interface tcwc_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [tcwc_pkg::CfgIdxW-1:0]   index;
  logic [tcwc_pkg::CfgDataW-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> rtl/three_color_weighted_composite_core.sv
// ----------------------------------------------------------------------------
// three_color_weighted_composite_core
// Per-pixel weighted mix of three channel colors into one clamped RGB value.
// ----------------------------------------------------------------------------
//  port     dir   role
//  cfg      in    register write: index 0..5, 64-bit data, always ready
//  pix_in   in    three samples plus no-data flags, one pixel per transfer
//  pix_out  out   red, green, blue, no_value, one per input transfer
//
//  One pixel per cycle sustained while pix_out is ready; the pipeline is
//  the lane stages (subtract, 32x32 scale multiply, color multiply) and the
//  merge register. Reset clears the stage valid bits and loads the register
//  defaults. Each stage moves when it is empty or the next one moves, so
//  bubbles close up and input is taken while a result waits at the output.
// ----------------------------------------------------------------------------
`default_nettype none

module three_color_weighted_composite_core (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  tcwc_cfg_if.sink    cfg,
  tcwc_in_if.sink     pix_in,
  tcwc_out_if.source  pix_out
);

  logic [tcwc_pkg::CfgDataW-1:0] prep_a_q, prep_b_q, prep_c_q;
  logic [tcwc_pkg::ColorW-1:0]   color_a_q, color_b_q, color_c_q;

  logic                  v1_q, v2_q, v3_q, v4_q;
  logic                  miss1_q, miss2_q, miss3_q;
  logic                  missing;
  tcwc_pkg::stage_en_t   en;
  tcwc_pkg::comp_prod_t  prod_a, prod_b, prod_c;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prep_a_q  <= tcwc_pkg::PrepReset;
      prep_b_q  <= tcwc_pkg::PrepReset;
      prep_c_q  <= tcwc_pkg::PrepReset;
      color_a_q <= tcwc_pkg::ColorAReset;
      color_b_q <= tcwc_pkg::ColorBReset;
      color_c_q <= tcwc_pkg::ColorCReset;
    end else if (cfg.valid) begin
      case (tcwc_pkg::cfg_reg_e'(cfg.index))
        tcwc_pkg::REG_PREP_A:  prep_a_q  <= cfg.data;
        tcwc_pkg::REG_PREP_B:  prep_b_q  <= cfg.data;
        tcwc_pkg::REG_PREP_C:  prep_c_q  <= cfg.data;
        tcwc_pkg::REG_COLOR_A: color_a_q <= cfg.data[tcwc_pkg::ColorW-1:0];
        tcwc_pkg::REG_COLOR_B: color_b_q <= cfg.data[tcwc_pkg::ColorW-1:0];
        tcwc_pkg::REG_COLOR_C: color_c_q <= cfg.data[tcwc_pkg::ColorW-1:0];
        default: ;
      endcase
    end
  end

  assign en.s4 = !v4_q || pix_out.ready;
  assign en.s3 = !v3_q || en.s4;
  assign en.s2 = !v2_q || en.s3;
  assign en.s1 = !v1_q || en.s2;

  assign pix_in.ready = en.s1;
  assign missing      = pix_in.nodata_a | pix_in.nodata_b | pix_in.nodata_c;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en.s1) v1_q <= pix_in.valid;
      if (en.s2) v2_q <= v1_q;
      if (en.s3) v3_q <= v2_q;
      if (en.s4) v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en.s1) miss1_q <= missing;
    if (en.s2) miss2_q <= miss1_q;
    if (en.s3) miss3_q <= miss2_q;
  end

  tcwc_lane u_lane_a (
    .clk_i    (clk_i),
    .en_i     (en),
    .sample_i (pix_in.sample_a),
    .prep_i   (prep_a_q),
    .color_i  (color_a_q),
    .prod_o   (prod_a)
  );

  tcwc_lane u_lane_b (
    .clk_i    (clk_i),
    .en_i     (en),
    .sample_i (pix_in.sample_b),
    .prep_i   (prep_b_q),
    .color_i  (color_b_q),
    .prod_o   (prod_b)
  );

  tcwc_lane u_lane_c (
    .clk_i    (clk_i),
    .en_i     (en),
    .sample_i (pix_in.sample_c),
    .prep_i   (prep_c_q),
    .color_i  (color_c_q),
    .prod_o   (prod_c)
  );

  tcwc_merge u_merge (
    .clk_i      (clk_i),
    .en_i       (en),
    .prod_a_i   (prod_a),
    .prod_b_i   (prod_b),
    .prod_c_i   (prod_c),
    .missing_i  (miss3_q),
    .red_o      (pix_out.red),
    .green_o    (pix_out.green),
    .blue_o     (pix_out.blue),
    .no_value_o (pix_out.no_value)
  );

  assign pix_out.valid = v4_q;

  a_nodata_black: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pix_out.valid && pix_out.no_value |->
      pix_out.red == '0 && pix_out.green == '0 && pix_out.blue == '0)
    else $error("no-data pixel with nonzero color");

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pix_in.ready |-> pix_out.valid && !pix_out.ready && v1_q && v2_q && v3_q)
    else $error("input stalled with a bubble in the pipeline");

  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pix_in.valid && pix_in.ready |=> v1_q)
    else $error("accepted pixel lost at first stage");

endmodule

`default_nettype wire

>>> rtl/tcwc_lane.sv
// ----------------------------------------------------------------------------
// tcwc_lane
// One channel: offset subtract, Q16.16 scale with clamp to 0..1.0, then the
// weight times each 8-bit color component. Three registered stages.
// ----------------------------------------------------------------------------
`default_nettype none

module tcwc_lane (
  input  wire logic                                 clk_i,
  input  wire tcwc_pkg::stage_en_t                  en_i,
  input  wire logic signed [tcwc_pkg::SampleW-1:0]  sample_i,
  input  wire logic [tcwc_pkg::CfgDataW-1:0]        prep_i,
  input  wire logic [tcwc_pkg::ColorW-1:0]          color_i,
  output      tcwc_pkg::comp_prod_t                 prod_o
);

  logic signed [tcwc_pkg::SampleW:0]        diff;
  logic                                     pos_d, pos_q;
  logic [tcwc_pkg::SampleW-1:0]             mag_q;
  logic [tcwc_pkg::SampleW+tcwc_pkg::ScaleW-1:0] scaled;
  logic [tcwc_pkg::WeightW-1:0]             weight_d, weight_q;
  tcwc_pkg::comp_prod_t                     prod_d, prod_q;

  assign diff  = {sample_i[tcwc_pkg::SampleW-1], sample_i}
               - {prep_i[tcwc_pkg::SampleW-1], prep_i[tcwc_pkg::SampleW-1:0]};
  assign pos_d = !diff[tcwc_pkg::SampleW] && (diff != '0);

  always_ff @(posedge clk_i) begin
    if (en_i.s1) begin
      pos_q <= pos_d;
      mag_q <= diff[tcwc_pkg::SampleW-1:0];
    end
  end

  assign scaled = {{tcwc_pkg::ScaleW{1'b0}}, mag_q}
                * {{tcwc_pkg::SampleW{1'b0}},
                   prep_i[tcwc_pkg::CfgDataW-1 -: tcwc_pkg::ScaleW]};

  always_comb begin
    if (!pos_q) begin
      weight_d = '0;
    end else if (|scaled[$bits(scaled)-1:tcwc_pkg::FracW]) begin
      weight_d = tcwc_pkg::WeightOne;
    end else begin
      weight_d = {1'b0, scaled[tcwc_pkg::FracW-1:0]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s2) begin
      weight_q <= weight_d;
    end
  end

  always_comb begin
    for (int k = 0; k < tcwc_pkg::NumComp; k++) begin
      prod_d[k] = tcwc_pkg::ProdW'(weight_q)
                * tcwc_pkg::ProdW'(color_i[k*tcwc_pkg::CompW +: tcwc_pkg::CompW]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s3) begin
      prod_q <= prod_d;
    end
  end

  assign prod_o = prod_q;

endmodule

`default_nettype wire

>>> rtl/tcwc_merge.sv
// ----------------------------------------------------------------------------
// tcwc_merge
// Sums the three lanes per component, drops the fraction, clamps to 255
// and forces zero colors on a no-data pixel. Output register stage.
// ----------------------------------------------------------------------------
`default_nettype none

module tcwc_merge (
  input  wire logic                          clk_i,
  input  wire tcwc_pkg::stage_en_t           en_i,
  input  wire tcwc_pkg::comp_prod_t          prod_a_i,
  input  wire tcwc_pkg::comp_prod_t          prod_b_i,
  input  wire tcwc_pkg::comp_prod_t          prod_c_i,
  input  wire logic                          missing_i,
  output      logic [tcwc_pkg::CompW-1:0]    red_o,
  output      logic [tcwc_pkg::CompW-1:0]    green_o,
  output      logic [tcwc_pkg::CompW-1:0]    blue_o,
  output      logic                          no_value_o
);

  logic [tcwc_pkg::NumComp-1:0][tcwc_pkg::SumW-1:0]  sum;
  logic [tcwc_pkg::NumComp-1:0][tcwc_pkg::CompW-1:0] comp_d, comp_q;
  logic                                              missing_q;

  always_comb begin
    for (int k = 0; k < tcwc_pkg::NumComp; k++) begin
      sum[k] = tcwc_pkg::SumW'(prod_a_i[k]) + tcwc_pkg::SumW'(prod_b_i[k])
             + tcwc_pkg::SumW'(prod_c_i[k]);
      if (missing_i) begin
        comp_d[k] = '0;
      end else if (|sum[k][tcwc_pkg::SumW-1:tcwc_pkg::FracW+tcwc_pkg::CompW]) begin
        comp_d[k] = tcwc_pkg::CompMax;
      end else begin
        comp_d[k] = sum[k][tcwc_pkg::FracW +: tcwc_pkg::CompW];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s4) begin
      comp_q    <= comp_d;
      missing_q <= missing_i;
    end
  end

  assign red_o      = comp_q[2];
  assign green_o    = comp_q[1];
  assign blue_o     = comp_q[0];
  assign no_value_o = missing_q;

endmodule

`default_nettype wire
